// ----- hw/rtl/bgfd_pkg.sv -----
// ----------------------------------------------------------------------------
// bgfd_pkg: shared types and constants of the binary command frame deframer
// Result codes, field identifiers, bitfield positions and the result type.
// ----------------------------------------------------------------------------
package bgfd_pkg;

  localparam int MAX_FRAME_DEF = 96;

  // Result kinds.
  localparam logic [2:0] KIND_FIELD  = 3'd0;
  localparam logic [2:0] KIND_OK     = 3'd1;
  localparam logic [2:0] KIND_BAD    = 3'd2;
  localparam logic [2:0] KIND_OVF    = 3'd3;
  localparam logic [2:0] KIND_NOTBIN = 3'd4;

  // Field identifiers and cursor codes.
  localparam logic [3:0] FID_N    = 4'd0;
  localparam logic [3:0] FID_M    = 4'd1;
  localparam logic [3:0] FID_G    = 4'd2;
  localparam logic [3:0] FID_T    = 4'd8;
  localparam logic [3:0] FID_TEXT = 4'd14;
  localparam logic [3:0] CUR_NONE = 4'd15;

  // Bit positions in the first bitfield word.
  localparam int BIT_START = 7;
  localparam int BIT_V2    = 12;
  localparam int BIT_TEXT  = 15;

  localparam logic [7:0] SUM_MOD = 8'd255;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  field_id;
    logic [31:0] value;
    logic        frame_end;
  } result_t;

endpackage

// ----- hw/rtl/bgfd_len.sv -----
// ----------------------------------------------------------------------------
// bgfd_len: frame length calculator
// Works out the total frame length in bytes from both bitfield words and the
// text length byte.
// ----------------------------------------------------------------------------
module bgfd_len (
  input  logic [15:0] first_bf,
  input  logic [15:0] second_bf,
  input  logic [7:0]  text_len_byte,
  output logic [7:0]  frame_len
);

  logic       v2;
  logic       txt;
  logic [7:0] n_bytes;
  logic [7:0] mg_cnt;
  logic [7:0] wide_cnt;
  logic [7:0] ijr_cnt;
  logic [7:0] text_bytes;
  logic [7:0] tail_bytes;

  always_comb begin
    v2  = first_bf[bgfd_pkg::BIT_V2];
    txt = first_bf[bgfd_pkg::BIT_TEXT];
    n_bytes  = first_bf[0] ? 8'd2 : 8'd0;
    mg_cnt   = 8'(first_bf[1]) + 8'(first_bf[2]);
    wide_cnt = 8'(first_bf[3]) + 8'(first_bf[4]) + 8'(first_bf[5]) + 8'(first_bf[6])
             + 8'(first_bf[8]) + 8'(first_bf[10]) + 8'(first_bf[11]);
    ijr_cnt  = 8'(second_bf[0]) + 8'(second_bf[1]) + 8'(second_bf[2]);
    // The length byte and the text together are capped at 80 bytes.
    text_bytes = (text_len_byte >= 8'd79) ? 8'd80 : text_len_byte + 8'd1;
    if (v2) begin
      tail_bytes = 8'd2 + (ijr_cnt << 2) + (txt ? text_bytes : 8'd0);
    end else begin
      tail_bytes = txt ? 8'd16 : 8'd0;
    end
    frame_len = 8'd4 + n_bytes + (v2 ? (mg_cnt << 1) : mg_cnt) + (wide_cnt << 2)
              + 8'(first_bf[9]) + tail_bytes;
  end

endmodule

// ----- hw/rtl/bgfd_core.sv -----
// ----------------------------------------------------------------------------
// bgfd_core: frame state and per-byte decode
// Holds the frame state and, for each byte that moves on, works out the
// next state and at most one result.
// ----------------------------------------------------------------------------
module bgfd_core #(
  parameter int MAX_FRAME = bgfd_pkg::MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output bgfd_pkg::result_t res
);

  logic [7:0]  position_r, position_nxt;
  logic [7:0]  frame_length_r, frame_length_nxt;
  logic [15:0] first_bf_r, first_bf_nxt;
  logic [15:0] second_bf_r, second_bf_nxt;
  logic [7:0]  sum_lo_r, sum_lo_nxt;
  logic [7:0]  sum_hi_r, sum_hi_nxt;
  logic [31:0] field_shift_r, field_shift_nxt;
  logic [3:0]  field_cursor_r, field_cursor_nxt;
  logic        low_match_r, low_match_nxt;
  logic [1:0]  field_count_r, field_count_nxt;

  logic [15:0] first_bf_w;
  logic [15:0] second_bf_w;
  logic [7:0]  len_byte;
  logic [7:0]  new_len;
  logic        len_ovf;
  logic        v2_w;
  logic        txt_w;
  logic [8:0]  pos_plus2;
  logic [8:0]  len_ext;
  logic [7:0]  lo_add;
  logic [7:0]  hi_add;
  logic [2:0]  cnt_inc;
  logic [31:0] shift_w;
  logic        do_clear;

  function automatic logic [7:0] add_mod(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, bgfd_pkg::SUM_MOD}) begin
      s = s - {1'b0, bgfd_pkg::SUM_MOD};
    end
    return s[7:0];
  endfunction

  function automatic logic [2:0] size_of(input logic [3:0] id, input logic v2);
    logic [2:0] sz;
    sz = 3'd4;
    if (id == bgfd_pkg::FID_N) begin
      sz = 3'd2;
    end else if (id == bgfd_pkg::FID_M || id == bgfd_pkg::FID_G) begin
      sz = v2 ? 3'd2 : 3'd1;
    end else if (id == bgfd_pkg::FID_T) begin
      sz = 3'd1;
    end
    return sz;
  endfunction

  // Lowest present field at or above 'from', else text or nothing.
  function automatic logic [3:0] next_field(input logic [3:0] from, input logic [15:0] fb,
                                            input logic [15:0] sb);
    logic [13:0] pv;
    logic [3:0]  id;
    pv = {sb[2:0] & {3{fb[bgfd_pkg::BIT_V2]}}, fb[11:8], fb[6:0]};
    id = fb[bgfd_pkg::BIT_TEXT] ? bgfd_pkg::FID_TEXT : bgfd_pkg::CUR_NONE;
    for (int k = 13; k >= 0; k--) begin
      if (pv[k] && (4'(k) >= from)) begin
        id = 4'(k);
      end
    end
    return id;
  endfunction

  bgfd_len u_len (
    .first_bf      (first_bf_w),
    .second_bf     (second_bf_w),
    .text_len_byte (len_byte),
    .frame_len     (new_len)
  );

  always_comb begin
    first_bf_w  = first_bf_r;
    second_bf_w = second_bf_r;
    if (position_r == 8'd1) begin
      first_bf_w[15:8] = rx_byte;
    end
    if (first_bf_r[bgfd_pkg::BIT_V2] && position_r == 8'd3) begin
      second_bf_w[15:8] = rx_byte;
    end
    v2_w     = first_bf_w[bgfd_pkg::BIT_V2];
    txt_w    = first_bf_w[bgfd_pkg::BIT_TEXT];
    len_byte = (v2_w && txt_w && position_r == 8'd4) ? rx_byte : 8'd0;
    len_ovf  = new_len > 8'(MAX_FRAME);

    pos_plus2 = {1'b0, position_r} + 9'd2;
    len_ext   = {1'b0, frame_length_r};
    lo_add    = add_mod(sum_lo_r, rx_byte);
    hi_add    = add_mod(sum_hi_r, lo_add);
    cnt_inc   = {1'b0, field_count_r} + 3'd1;
    shift_w   = field_shift_r | (32'(rx_byte) << {field_count_r, 3'b000});

    position_nxt     = position_r;
    frame_length_nxt = frame_length_r;
    first_bf_nxt     = first_bf_r;
    second_bf_nxt    = second_bf_r;
    sum_lo_nxt       = sum_lo_r;
    sum_hi_nxt       = sum_hi_r;
    field_shift_nxt  = field_shift_r;
    field_cursor_nxt = field_cursor_r;
    low_match_nxt    = low_match_r;
    field_count_nxt  = field_count_r;
    do_clear         = 1'b0;
    res_valid        = 1'b0;
    res              = '0;

    if (position_r == 8'd0) begin
      if (rx_byte == 8'd0) begin
        res_valid = 1'b0;
      end else if (!rx_byte[bgfd_pkg::BIT_START]) begin
        res_valid = 1'b1;
        res.kind  = bgfd_pkg::KIND_NOTBIN;
        res.value = 32'(rx_byte);
      end else begin
        position_nxt     = 8'd1;
        frame_length_nxt = 8'd0;
        first_bf_nxt     = 16'(rx_byte);
        second_bf_nxt    = 16'd0;
        sum_lo_nxt       = add_mod(8'd0, rx_byte);
        sum_hi_nxt       = sum_lo_nxt;
        field_shift_nxt  = 32'd0;
        field_cursor_nxt = 4'd0;
        low_match_nxt    = 1'b0;
        field_count_nxt  = 2'd0;
      end
    end else begin
      position_nxt = position_r + 8'd1;
      // Checksum bytes stay out of the running sums once the length is known.
      if (frame_length_r == 8'd0 || pos_plus2 < len_ext) begin
        sum_lo_nxt = lo_add;
        sum_hi_nxt = hi_add;
      end
      if (position_r == 8'd1) begin
        first_bf_nxt = first_bf_w;
        if (!v2_w) begin
          if (len_ovf) begin
            do_clear = 1'b1;
          end else begin
            frame_length_nxt = new_len;
            field_cursor_nxt = next_field(4'd0, first_bf_w, second_bf_w);
          end
        end
      end else if (v2_w && position_r == 8'd2) begin
        second_bf_nxt = 16'(rx_byte);
      end else if (v2_w && position_r == 8'd3) begin
        second_bf_nxt = second_bf_w;
        if (len_ovf) begin
          do_clear = 1'b1;
        end else begin
          frame_length_nxt = new_len;
          if (!txt_w) begin
            field_cursor_nxt = next_field(4'd0, first_bf_w, second_bf_w);
          end
        end
      end else if (v2_w && txt_w && position_r == 8'd4) begin
        if (len_ovf) begin
          do_clear = 1'b1;
        end else begin
          frame_length_nxt = new_len;
          field_cursor_nxt = next_field(4'd0, first_bf_w, second_bf_w);
        end
      end else if (frame_length_r < 8'd4) begin
        do_clear = 1'b1;
      end else if (pos_plus2 < len_ext) begin
        if (field_cursor_r < bgfd_pkg::FID_TEXT) begin
          if (cnt_inc >= size_of(field_cursor_r, v2_w)) begin
            res_valid        = 1'b1;
            res.kind         = bgfd_pkg::KIND_FIELD;
            res.field_id     = field_cursor_r;
            res.value        = shift_w;
            field_shift_nxt  = 32'd0;
            field_count_nxt  = 2'd0;
            field_cursor_nxt = next_field(field_cursor_r + 4'd1, first_bf_r, second_bf_r);
          end else begin
            field_shift_nxt = shift_w;
            field_count_nxt = cnt_inc[1:0];
          end
        end else if (field_cursor_r == bgfd_pkg::FID_TEXT) begin
          res_valid    = 1'b1;
          res.kind     = bgfd_pkg::KIND_FIELD;
          res.field_id = bgfd_pkg::FID_TEXT;
          res.value    = 32'(rx_byte);
        end
      end else if (pos_plus2 == len_ext) begin
        low_match_nxt = (rx_byte == sum_lo_r);
      end else begin
        res_valid     = 1'b1;
        res.kind      = (low_match_r && rx_byte == sum_hi_r) ? bgfd_pkg::KIND_OK
                                                             : bgfd_pkg::KIND_BAD;
        res.value     = {second_bf_r, first_bf_r};
        res.frame_end = 1'b1;
        do_clear      = 1'b1;
      end
      // An overflow reports both bitfield words as they stand after this byte.
      if (do_clear && (position_r < 8'd5) && frame_length_r != 8'd4 && len_ovf &&
          (position_r == 8'd1 || position_r == 8'd3 || position_r == 8'd4) &&
          !res_valid) begin
        res_valid     = 1'b1;
        res.kind      = bgfd_pkg::KIND_OVF;
        res.value     = {second_bf_w, first_bf_w};
        res.frame_end = 1'b1;
      end
    end

    if (do_clear) begin
      position_nxt     = 8'd0;
      frame_length_nxt = 8'd0;
      first_bf_nxt     = 16'd0;
      second_bf_nxt    = 16'd0;
      sum_lo_nxt       = 8'd0;
      sum_hi_nxt       = 8'd0;
      field_shift_nxt  = 32'd0;
      field_cursor_nxt = 4'd0;
      low_match_nxt    = 1'b0;
      field_count_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r     <= 8'd0;
      frame_length_r <= 8'd0;
      first_bf_r     <= 16'd0;
      second_bf_r    <= 16'd0;
      sum_lo_r       <= 8'd0;
      sum_hi_r       <= 8'd0;
      field_shift_r  <= 32'd0;
      field_cursor_r <= 4'd0;
      low_match_r    <= 1'b0;
      field_count_r  <= 2'd0;
    end else if (advance) begin
      position_r     <= position_nxt;
      frame_length_r <= frame_length_nxt;
      first_bf_r     <= first_bf_nxt;
      second_bf_r    <= second_bf_nxt;
      sum_lo_r       <= sum_lo_nxt;
      sum_hi_r       <= sum_hi_nxt;
      field_shift_r  <= field_shift_nxt;
      field_cursor_r <= field_cursor_nxt;
      low_match_r    <= low_match_nxt;
      field_count_r  <= field_count_nxt;
    end
  end

endmodule

// ----- hw/rtl/binary_gcode_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// binary_gcode_frame_deframer: binary command frame deframer
// Splits a serial byte stream into binary command frames, emits each field
// and text byte and gives a Fletcher-16 checksum verdict per frame.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while no result waits on out_tready: a
// byte lands in the input register, is decoded against the frame state
// combinationally and its result, if any, is registered in the output
// register, from where it is presented. Zero bytes between frames produce
// nothing; every other byte outside a frame with bit 7 clear gives a
// not-binary result. Each frame ends in exactly one result with tlast set: a
// good or bad checksum verdict, or an overflow as soon as the known frame
// length exceeds MAX_FRAME, after which the following bytes are taken as
// fresh input. A result that waits on out_tready holds one further byte in
// the input register; beyond that the input side stalls.
module binary_gcode_frame_deframer #(
  parameter int MAX_FRAME = bgfd_pkg::MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] field_id, [35:4] value, [39:36] zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // frame_end
);

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              out_valid_r;
  bgfd_pkg::result_t out_r;
  logic              advance;
  logic              res_valid;
  bgfd_pkg::result_t res;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  bgfd_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r.value, out_r.field_id};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.frame_end;

endmodule

// ----- tb/tb_binary_gcode_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// tb_binary_gcode_frame_deframer: self-checking bench for the frame deframer
// Drives a short table of hand-built byte sequences and then a long run of
// random frames and noise. A byte-level decoder in the bench predicts each
// item not given by a table row, and each one is compared field by field.
// ----------------------------------------------------------------------------
module tb_binary_gcode_frame_deframer;

  localparam int ITEMS_TOTAL = 1850;
  localparam int PHASE_B_AT  = 620;
  localparam int PHASE_C_AT  = 1240;
  localparam int HOLD_AT     = 1320;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 8;

  localparam logic [3:0] FID_E = 4'd6;
  localparam logic [3:0] FID_P = 4'd10;
  localparam logic [3:0] FID_I = 4'd11;
  localparam logic [3:0] FID_R = 4'd13;
  localparam int TEXT_CAP = 80;
  localparam int TEXT_V1  = 16;

  typedef enum logic [1:0] {SRC_LIT, SRC_LO, SRC_HI} src_t;
  typedef enum logic [1:0] {EXP_CALC, EXP_NONE, EXP_TYPED} exp_t;

  typedef struct packed {
    logic [7:0]        data;
    src_t              src;
    exp_t              chk;
    bgfd_pkg::result_t res;
  } row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // Decoder state of the bench.
  logic [7:0]  frame_pos = '0;
  int          frame_len = 0;
  logic [15:0] word_lo   = '0;
  logic [15:0] word_hi   = '0;
  logic [7:0]  fl_lo     = '0;
  logic [7:0]  fl_hi     = '0;
  logic [31:0] acc_bits  = '0;
  logic [2:0]  acc_count = '0;
  logic [3:0]  cur_field = '0;
  logic        lo_ok     = 1'b0;

  bgfd_pkg::result_t due_results [$];
  int      n_bytes_sent = 0;
  int      n_mismatch   = 0;
  int      tx_gap_pct   = 0;
  int      rx_stall_pct = 0;
  bit      hold_done    = 1'b0;

  // Hand-built sequences: an idle zero, an ASCII byte, a frame with a
  // checksum byte of 255, an overflowing text length, and a small version 2
  // frame whose checksum is filled in from the running sums.
  row_t steps [0:25] = '{
    '{8'h00, SRC_LIT, EXP_NONE,  '0},
    '{8'h7F, SRC_LIT, EXP_TYPED, '{bgfd_pkg::KIND_NOTBIN, 4'd0, 32'h0000_007F, 1'b0}},
    '{8'h80, SRC_LIT, EXP_CALC,  '0},
    '{8'h00, SRC_LIT, EXP_CALC,  '0},
    '{8'hFF, SRC_LIT, EXP_CALC,  '0},
    '{8'hFF, SRC_LIT, EXP_TYPED, '{bgfd_pkg::KIND_BAD, 4'd0, 32'h0000_0080, 1'b1}},
    '{8'hFF, SRC_LIT, EXP_CALC,  '0},
    '{8'h9F, SRC_LIT, EXP_CALC,  '0},
    '{8'h07, SRC_LIT, EXP_CALC,  '0},
    '{8'h00, SRC_LIT, EXP_CALC,  '0},
    '{8'hFF, SRC_LIT, EXP_TYPED, '{bgfd_pkg::KIND_OVF, 4'd0, 32'h0007_9FFF, 1'b1}},
    '{8'h82, SRC_LIT, EXP_CALC,  '0},
    '{8'h92, SRC_LIT, EXP_CALC,  '0},
    '{8'h01, SRC_LIT, EXP_CALC,  '0},
    '{8'h00, SRC_LIT, EXP_CALC,  '0},
    '{8'h01, SRC_LIT, EXP_CALC,  '0},
    '{8'h34, SRC_LIT, EXP_CALC,  '0},
    '{8'h12, SRC_LIT, EXP_CALC,  '0},
    '{8'hFF, SRC_LIT, EXP_CALC,  '0},
    '{8'h78, SRC_LIT, EXP_CALC,  '0},
    '{8'h56, SRC_LIT, EXP_CALC,  '0},
    '{8'h34, SRC_LIT, EXP_CALC,  '0},
    '{8'h12, SRC_LIT, EXP_CALC,  '0},
    '{8'h41, SRC_LIT, EXP_CALC,  '0},
    '{8'h00, SRC_LO,  EXP_CALC,  '0},
    '{8'h00, SRC_HI,  EXP_CALC,  '0}
  };

  binary_gcode_frame_deframer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit ver2();
    return word_lo[bgfd_pkg::BIT_V2];
  endfunction

  function automatic bit with_text();
    return word_lo[bgfd_pkg::BIT_TEXT];
  endfunction

  function automatic int field_bytes(input int id);
    if (id == bgfd_pkg::FID_N) return 2;
    if (id == bgfd_pkg::FID_M || id == bgfd_pkg::FID_G) return ver2() ? 2 : 1;
    if (id == bgfd_pkg::FID_T) return 1;
    return 4;
  endfunction

  // The F, T, S and P flags sit one place above their ids, past the start bit.
  function automatic bit field_here(input int id);
    if (id <= FID_E) return word_lo[id];
    if (id <= FID_P) return word_lo[id + 1];
    if (id <= FID_R) return ver2() && word_hi[id - FID_I];
    return 1'b0;
  endfunction

  function automatic logic [3:0] next_present(input int from);
    for (int id = from; id <= FID_R; id++)
      if (field_here(id)) return 4'(id);
    return with_text() ? bgfd_pkg::FID_TEXT : bgfd_pkg::CUR_NONE;
  endfunction

  function automatic int frame_bytes(input logic [7:0] len_byte);
    int total;
    total = 4;
    for (int id = bgfd_pkg::FID_N; id <= FID_R; id++)
      if (field_here(id)) total += field_bytes(id);
    if (ver2()) begin
      total += 2;
      if (with_text())
        total += (int'(len_byte) + 1 < TEXT_CAP) ? int'(len_byte) + 1 : TEXT_CAP;
    end else if (with_text()) begin
      total += TEXT_V1;
    end
    return total;
  endfunction

  function automatic void fold_sum(input logic [7:0] b);
    int lo;
    int hi;
    lo = int'(fl_lo) + int'(b);
    if (lo >= int'(bgfd_pkg::SUM_MOD)) lo -= int'(bgfd_pkg::SUM_MOD);
    hi = int'(fl_hi) + lo;
    if (hi >= int'(bgfd_pkg::SUM_MOD)) hi -= int'(bgfd_pkg::SUM_MOD);
    fl_lo = 8'(lo);
    fl_hi = 8'(hi);
  endfunction

  function automatic void drop_frame();
    frame_pos = '0;
    frame_len = 0;
    word_lo   = '0;
    word_hi   = '0;
    fl_lo     = '0;
    fl_hi     = '0;
    acc_bits  = '0;
    acc_count = '0;
    cur_field = '0;
    lo_ok     = 1'b0;
  endfunction

  function automatic bit settle_length(input logic [7:0] len_byte, output bit got,
                                       output bgfd_pkg::result_t res);
    got = 1'b0;
    res = '0;
    frame_len = frame_bytes(len_byte);
    if (frame_len > bgfd_pkg::MAX_FRAME_DEF) begin
      got = 1'b1;
      res.kind = bgfd_pkg::KIND_OVF;
      res.value = {word_hi, word_lo};
      res.frame_end = 1'b1;
      drop_frame();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, output bit got,
                                      output bgfd_pkg::result_t res);
    int idx;
    got = 1'b0;
    res = '0;
    if (frame_pos == 0) begin
      if (b == 8'h00) return;
      if (!b[bgfd_pkg::BIT_START]) begin
        got = 1'b1;
        res.kind = bgfd_pkg::KIND_NOTBIN;
        res.value = {24'h0, b};
        return;
      end
      drop_frame();
      word_lo = {8'h00, b};
      fold_sum(b);
      frame_pos = 8'd1;
      return;
    end
    idx = int'(frame_pos);
    frame_pos = frame_pos + 8'd1;
    // The two checksum bytes stay out of the sums once the length is known.
    if (frame_len == 0 || idx + 2 < frame_len) fold_sum(b);
    if (idx == 1) begin
      word_lo[15:8] = b;
      if (!ver2()) begin
        if (settle_length(8'h00, got, res)) return;
        cur_field = next_present(0);
      end
      return;
    end
    if (ver2() && idx == 2) begin
      word_hi[7:0] = b;
      return;
    end
    if (ver2() && idx == 3) begin
      word_hi[15:8] = b;
      if (settle_length(8'h00, got, res)) return;
      if (!with_text()) cur_field = next_present(0);
      return;
    end
    if (ver2() && with_text() && idx == 4) begin
      if (settle_length(b, got, res)) return;
      cur_field = next_present(0);
      return;
    end
    if (idx + 2 < frame_len) begin
      if (cur_field < bgfd_pkg::FID_TEXT) begin
        acc_bits = acc_bits | (32'(b) << (8 * acc_count[1:0]));
        acc_count = acc_count + 3'd1;
        if (int'(acc_count) >= field_bytes(cur_field)) begin
          got = 1'b1;
          res.kind = bgfd_pkg::KIND_FIELD;
          res.field_id = cur_field;
          res.value = acc_bits;
          acc_bits = '0;
          acc_count = '0;
          cur_field = next_present(int'(cur_field) + 1);
        end
      end else if (cur_field == bgfd_pkg::FID_TEXT) begin
        got = 1'b1;
        res.kind = bgfd_pkg::KIND_FIELD;
        res.field_id = bgfd_pkg::FID_TEXT;
        res.value = {24'h0, b};
      end
      return;
    end
    if (idx + 2 == frame_len) begin
      lo_ok = (b == fl_lo);
      return;
    end
    got = 1'b1;
    res.kind = (lo_ok && b == fl_hi) ? bgfd_pkg::KIND_OK : bgfd_pkg::KIND_BAD;
    res.value = {word_hi, word_lo};
    res.frame_end = 1'b1;
    drop_frame();
  endfunction

  // Offers one byte and returns at the edge where it is taken. Where typed is
  // set, the given expectation replaces the decoder's.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input bit typed_has = 1'b0,
                           input bgfd_pkg::result_t typed_res = '0);
    bit                got;
    bgfd_pkg::result_t res;
    if (!(frame_pos == 0 && b == 8'h00)) n_bytes_sent++;
    decode_byte(b, got, res);
    if (typed) begin
      got = typed_has;
      res = typed_res;
    end
    if (got) due_results.push_back(res);
    while ($urandom_range(1, 100) <= tx_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  // One frame with random content, steered by the decoder's view of where
  // the frame stands. A spoilt frame gets random or 255 checksum bytes.
  task automatic send_frame(input bit spoil);
    logic [7:0] b;
    send_byte(8'h80 | 8'($urandom_range(0, 127)));
    while (frame_pos != 0) begin
      b = 8'($urandom_range(0, 255));
      if (frame_pos == 8'd4 && ver2() && with_text()) begin
        if ($urandom_range(0, 5) != 0) b = 8'($urandom_range(0, 30));
      end else if (frame_len != 0 && int'(frame_pos) + 2 == frame_len) begin
        if (!spoil) begin
          b = fl_lo;
        end else begin
          case ($urandom_range(0, 2))
            0: b = fl_lo;
            1: b = 8'hFF;
            default: ;
          endcase
        end
      end else if (frame_len != 0 && int'(frame_pos) + 1 == frame_len) begin
        if (!spoil) b = fl_hi;
        else if ($urandom_range(0, 1) == 0) b = 8'hFF;
      end
      send_byte(b);
    end
  endtask

  // The sender stops offering while the block drains.
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] b;
    drop_frame();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    tx_gap_pct   = 16;
    rx_stall_pct = 65;
    foreach (steps[k]) begin
      b = steps[k].data;
      if (steps[k].src == SRC_LO) b = fl_lo;
      else if (steps[k].src == SRC_HI) b = fl_hi;
      send_byte(b, steps[k].chk != EXP_CALC, steps[k].chk == EXP_TYPED, steps[k].res);
    end
    wait_all_results();

    while (n_bytes_sent < ITEMS_TOTAL) begin
      if (n_bytes_sent >= PHASE_C_AT && tx_gap_pct != 0) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else if (n_bytes_sent >= PHASE_B_AT && n_bytes_sent < PHASE_C_AT &&
                   tx_gap_pct != 65) begin
        // Let the block run dry before the idling pattern turns round.
        wait_all_results();
        tx_gap_pct   = 65;
        rx_stall_pct = 16;
      end
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 4)) begin
            b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 127));
            send_byte(b);
          end
        end
        1, 2: send_frame(1'b1);
        default: send_frame(1'b0);
      endcase
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_mismatch == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: random stalls, and one long hold-off so that the block
  // backs up and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (!hold_done && n_bytes_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(1, 100) > rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    bgfd_pkg::result_t seen;
    bgfd_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.kind      = out_tuser;
      seen.field_id  = out_tdata[3:0];
      seen.value     = out_tdata[35:4];
      seen.frame_end = out_tlast;
      if (due_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result: kind %0d id %0d value %h last %0b",
                   seen.kind, seen.field_id, seen.value, seen.frame_end);
      end else begin
        want = due_results.pop_front();
        if (seen.kind !== want.kind || seen.field_id !== want.field_id ||
            seen.value !== want.value || seen.frame_end !== want.frame_end) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("result mismatch: expected kind %0d id %0d value %h last %0b, %s",
                     want.kind, want.field_id, want.value, want.frame_end,
                     $sformatf("got kind %0d id %0d value %h last %0b",
                               seen.kind, seen.field_id, seen.value, seen.frame_end));
        end
      end
    end
  end

  initial begin
    #(12 * 400000);
    $display("Some tests failed");
    $finish;
  end

endmodule
